/* design/trm_pkg.sv */
// Shared types and constants for the triangle mask rasterizer.
package trm_pkg;

  localparam int CoordW = 16;
  localparam int IdxW   = 13;
  localparam int DiffW  = 18;
  localparam int ProdW  = 2 * DiffW;
  localparam int AccW   = 40;
  localparam int SizeW  = 7;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] vx0;
    logic signed [CoordW-1:0] vy0;
    logic signed [CoordW-1:0] vx1;
    logic signed [CoordW-1:0] vy1;
    logic signed [CoordW-1:0] vx2;
    logic signed [CoordW-1:0] vy2;
    logic                     final_triangle;
  } item_t;

  typedef struct packed {
    logic [5:0]  row_index;
    logic [63:0] row_bits;
    logic        last_row;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_SETUP,
    ST_LOAD,
    ST_PIX,
    ST_WRITE,
    ST_READ,
    ST_FLUSH
  } state_t;

endpackage

/* design/trm_axis.sv */
// Bounding-box range of one axis: clamped, floored low index and truncated high index.
module trm_axis (
  input  logic signed [trm_pkg::CoordW-1:0] a,
  input  logic signed [trm_pkg::CoordW-1:0] b,
  input  logic signed [trm_pkg::CoordW-1:0] c,
  input  logic        [trm_pkg::SizeW-1:0]  size,
  output logic signed [trm_pkg::IdxW-1:0]   beg,
  output logic signed [trm_pkg::IdxW-1:0]   fin
);
  import trm_pkg::*;

  logic signed [CoordW-1:0] lo, hi, lo_c;
  logic signed [CoordW:0]   lim, hi_c, t, t_adj;

  always_comb begin
    lo = (a < b) ? a : b;
    lo = (lo < c) ? lo : c;
    hi = (a > b) ? a : b;
    hi = (hi > c) ? hi : c;
    lim = $signed({1'b0, 4'(0), size, 4'b0}) - 17'sd32;
    lo_c = (lo < 0) ? '0 : lo;
    hi_c = (CoordW'(hi) > lim) ? lim : (CoordW+1)'(hi);
    t = hi_c + 17'sd16;
    // Division by 16 truncates toward zero, so negative values round up.
    t_adj = (t < 0) ? t + 17'sd15 : t;
    beg = IdxW'(lo_c >>> 4);
    fin = IdxW'(t_adj >>> 4);
  end

endmodule

/* design/triangle_mask_rasterizer.sv */
// Top level of the triangle mask rasterizer: sequencer, shared multiplier and mask memory.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------
//  triangle  | start / busy           | item   (item_t)
//  result    | result_valid (strobe)  | result (result_t)
//  config    | cfg_we                 | cfg_index, cfg_data
//
// A triangle passes through the box state, the setup steps on the shared multiplier and a load state,
// then walks its bounding box one pixel a cycle, with a write state after each row.
// A final triangle adds a read-out of every row up to the image height, one row per cycle from the mask
// memory port. Reset clears every row at once through per-row valid bits.
// Results are strobed for one cycle each; the receiver cannot stall them.
module triangle_mask_rasterizer #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  trm_pkg::item_t                      item,
  output logic                                result_valid,
  output trm_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [trm_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [trm_pkg::SizeW-1:0]           cfg_data
);
  import trm_pkg::*;

  localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  state_t state, state_next;

  logic [SizeW-1:0] image_width, image_height, w_eff, h_eff;
  item_t tri_q;

  logic signed [IdxW-1:0] bx, ex, by, ey;
  logic signed [IdxW-1:0] bx_c, ex_c, by_c, ey_c;
  logic signed [IdxW-1:0] xi, yi;

  logic [3:0] step;
  logic signed [DiffW-1:0] op_a, op_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  dsum;
  logic signed [AccW-1:0]  rs [3];
  logic signed [AccW-1:0]  cur [3];
  logic signed [DiffW-1:0] nx [3];
  logic signed [DiffW-1:0] ny [3];
  logic signed [DiffW-1:0] pxs, pys;
  logic                    pix_hit;

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_valid;
  logic [MAX_WIDTH-1:0] rdata, rowacc, colmask;
  logic [RW-1:0] rd_addr, rd_row, rcnt;
  logic rd_vld, rd_pend, rd_last;
  logic box_empty;

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 7'd64;
      image_height <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (image_width < 7'd2) ? 7'd2 :
            (image_width > SizeW'(MAX_WIDTH)) ? SizeW'(MAX_WIDTH) : image_width;
    h_eff = (image_height < 7'd2) ? 7'd2 :
            (image_height > SizeW'(MAX_HEIGHT)) ? SizeW'(MAX_HEIGHT) : image_height;
    for (int i = 0; i < MAX_WIDTH; i++) colmask[i] = (SizeW'(i) < w_eff);
  end

  trm_axis u_axis_x (.a(tri_q.vx0), .b(tri_q.vx1), .c(tri_q.vx2), .size(w_eff),
                     .beg(bx_c), .fin(ex_c));
  trm_axis u_axis_y (.a(tri_q.vy0), .b(tri_q.vy1), .c(tri_q.vy2), .size(h_eff),
                     .beg(by_c), .fin(ey_c));

  assign box_empty = (ex < bx) || (ey < by);

  // Edge normals; the edge function grows by 16*nx per column and 16*ny per row.
  always_comb begin
    nx[0] = DiffW'(tri_q.vy0) - DiffW'(tri_q.vy1);
    ny[0] = DiffW'(tri_q.vx1) - DiffW'(tri_q.vx0);
    nx[1] = DiffW'(tri_q.vy1) - DiffW'(tri_q.vy2);
    ny[1] = DiffW'(tri_q.vx2) - DiffW'(tri_q.vx1);
    nx[2] = DiffW'(tri_q.vy2) - DiffW'(tri_q.vy0);
    ny[2] = DiffW'(tri_q.vx0) - DiffW'(tri_q.vx2);
    pxs = DiffW'(bx) <<< 4;
    pys = DiffW'(by) <<< 4;
  end

  // Operand schedule of the shared multiplier: triangle area first, then each
  // edge function at the first pixel of the box.
  always_comb begin
    unique case (step)
      4'd0:    begin op_a = DiffW'(tri_q.vx2) - DiffW'(tri_q.vx0); op_b = nx[0]; end
      4'd1:    begin op_a = DiffW'(tri_q.vy2) - DiffW'(tri_q.vy0); op_b = ny[0]; end
      4'd2:    begin op_a = pxs - DiffW'(tri_q.vx0); op_b = nx[0]; end
      4'd3:    begin op_a = pys - DiffW'(tri_q.vy0); op_b = ny[0]; end
      4'd4:    begin op_a = pxs - DiffW'(tri_q.vx1); op_b = nx[1]; end
      4'd5:    begin op_a = pys - DiffW'(tri_q.vy1); op_b = ny[1]; end
      4'd6:    begin op_a = pxs - DiffW'(tri_q.vx2); op_b = nx[2]; end
      4'd7:    begin op_a = pys - DiffW'(tri_q.vy2); op_b = ny[2]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // A pixel passes if the area is zero or each edge function is zero or has its sign.
  always_comb begin
    pix_hit = 1'b1;
    for (int e = 0; e < 3; e++) begin
      if (dsum > 0 && cur[e] < 0) pix_hit = 1'b0;
      if (dsum < 0 && cur[e] > 0) pix_hit = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_BOX;
      ST_BOX:   state_next = ST_SETUP;
      ST_SETUP: if (step == 4'd8) begin
        priority if (box_empty) state_next = tri_q.final_triangle ? ST_READ : ST_IDLE;
        else state_next = ST_LOAD;
      end
      ST_LOAD:  state_next = ST_PIX;
      ST_PIX:   if (xi == ex) state_next = ST_WRITE;
      ST_WRITE: if (yi == ey) state_next = tri_q.final_triangle ? ST_READ : ST_IDLE;
                else state_next = ST_PIX;
      ST_READ:  if (rcnt == RW'(h_eff - 7'd1)) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    rd_addr = (state == ST_READ) ? rcnt : yi[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      rcnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (start) tri_q <= item;
        ST_BOX: begin
          bx <= bx_c; ex <= ex_c; by <= by_c; ey <= ey_c;
          step <= '0;
        end
        ST_SETUP: begin
          step <= step + 4'd1;
          prod <= op_a * op_b;
          if (step != 4'd0) begin
            unique case (step)
              4'd1: dsum  <= AccW'(prod);
              4'd2: dsum  <= dsum + AccW'(prod);
              4'd3: rs[0] <= AccW'(prod);
              4'd4: rs[0] <= rs[0] + AccW'(prod);
              4'd5: rs[1] <= AccW'(prod);
              4'd6: rs[1] <= rs[1] + AccW'(prod);
              4'd7: rs[2] <= AccW'(prod);
              4'd8: rs[2] <= rs[2] + AccW'(prod);
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          for (int e = 0; e < 3; e++) cur[e] <= rs[e];
          xi <= bx; yi <= by;
          rowacc <= '0;
        end
        ST_PIX: begin
          if (pix_hit) rowacc[xi[CW-1:0]] <= 1'b1;
          if (xi != ex) begin
            xi <= xi + IdxW'(1);
            for (int e = 0; e < 3; e++) cur[e] <= cur[e] + (AccW'(nx[e]) <<< 4);
          end
        end
        ST_WRITE: begin
          xi <= bx; yi <= yi + IdxW'(1);
          rowacc <= '0;
          for (int e = 0; e < 3; e++) begin
            rs[e]  <= rs[e] + (AccW'(ny[e]) <<< 4);
            cur[e] <= rs[e] + (AccW'(ny[e]) <<< 4);
          end
        end
        ST_READ:  rcnt <= rcnt + RW'(1);
        ST_FLUSH: rcnt <= '0;
        default: ;
      endcase
    end
  end

  // Mask memory: one read port, one write port, rows cleared through valid bits.
  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (state == ST_WRITE)
      mem[yi[RW-1:0]] <= (row_valid[yi[RW-1:0]] ? rdata : '0) | rowacc;
  end

  always_ff @(posedge clk) begin
    if (rst) row_valid <= '0;
    else if (state == ST_FLUSH) row_valid <= '0;
    else if (state == ST_WRITE) row_valid[yi[RW-1:0]] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ST_READ);
      rd_vld  <= row_valid[rd_addr];
      rd_row  <= rcnt;
      rd_last <= (rcnt == RW'(h_eff - 7'd1));
    end
  end

  always_comb begin
    result_valid     = rd_pend;
    result.row_index = 6'(rd_row);
    result.row_bits  = 64'((rd_vld ? rdata : '0) & colmask);
    result.last_row  = rd_last;
  end

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result strobed while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted triangle not taken up");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_row) |=> !result_valid)
    else $error("result after last row");
  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_row) |=>
      (result_valid && result.row_index == $past(result.row_index) + 6'd1))
    else $error("read-out rows out of sequence");

endmodule
